>>> sv/pccc_pkg.sv
// Shared types and constants for the pixel claim collision checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pccc_pkg;

  // Field widths of one input transaction and one result transaction
  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 8;
  localparam int CAMSEL_W = 2;
  localparam int OWNER_W  = 16;
  localparam int PIX_W    = 14;
  localparam int PROD_W   = 2 * SIZE_W;
  // Map entry: claimed bit on top of the owner
  localparam int ENTRY_W  = OWNER_W + 1;

  // Packed stream widths (whole bytes)
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  // Command codes carried on in_tuser
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // One accepted input transaction, unpacked
  typedef struct packed {
    logic                       cmd;
    logic [CAMSEL_W-1:0]        camera;
    logic signed [COORD_W-1:0]  x_pos;
    logic signed [COORD_W-1:0]  y_pos;
    logic [SIZE_W-1:0]          image_width;
    logic [SIZE_W-1:0]          image_height;
    logic [OWNER_W-1:0]         point_index;
  } pccc_item_t;

  // Control and payload that travel with an address through the pipeline
  typedef struct packed {
    logic               valid;
    logic               clear;
    logic [OWNER_W-1:0] point_index;
    logic [PIX_W-1:0]   pix;
  } pccc_tag_t;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_INIT  = 3'b001,
    ST_RUN   = 3'b010,
    ST_CLEAR = 3'b100
  } pccc_state_t;

endpackage

`default_nettype wire

>>> sv/pccc_owner_mem.sv
// Owner map storage: one write port, one read port, registered read data.
// Depends on pccc_pkg for the entry width.
`default_nettype none

module pccc_owner_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [ADDR_W-1:0]             wr_addr,
  input  wire [pccc_pkg::ENTRY_W-1:0]  wr_data,
  input  wire                          rd_en,
  input  wire [ADDR_W-1:0]             rd_addr,
  output logic [pccc_pkg::ENTRY_W-1:0] rd_data
);
  import pccc_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered (old data on same-address write)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/pccc_coord.sv
// Address generation: size clamp, rounding, camera wrap, then row*width+col.
// Two pipeline stages that advance together with the rest of the block.
// Depends on pccc_pkg.
`default_nettype none

module pccc_coord #(
  parameter int MAX_CAMERAS = 4,
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int ADDR_W      = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  adv,
  input  wire                  in_valid,
  input  pccc_pkg::pccc_item_t in_item,
  output pccc_pkg::pccc_tag_t  out_tag,
  output logic [ADDR_W-1:0]    out_addr
);
  import pccc_pkg::*;

  localparam int CAM_SPAN = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [SIZE_W-1:0] W_LIM = SIZE_W'((MAX_WIDTH < 255) ? MAX_WIDTH : 255);
  localparam logic [SIZE_W-1:0] H_LIM = SIZE_W'((MAX_HEIGHT < 255) ? MAX_HEIGHT : 255);
  localparam logic [4:0] CAM_MOD = 5'(MAX_CAMERAS);

  // size forced into 1..lim
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] s;
    begin
      s = (v == '0) ? SIZE_W'(1) : v;
      if (s > lim) s = lim;
      return s;
    end
  endfunction

  // add one half, truncate, clamp to 0..size-1
  function automatic logic [SIZE_W-1:0] round_clamp(input logic signed [COORD_W-1:0] raw,
                                                    input logic [SIZE_W-1:0] size);
    logic signed [COORD_W:0] s;
    logic [COORD_W-5:0]      p;
    logic [COORD_W-5:0]      lim;
    begin
      s   = {raw[COORD_W-1], raw} + (COORD_W+1)'(8);
      p   = s[COORD_W-1:4];
      lim = (COORD_W-4)'(size - SIZE_W'(1));
      if (s[COORD_W]) p = '0;
      else if (p > lim) p = lim;
      return SIZE_W'(p);
    end
  endfunction

  // ---------------- stage 2: per-axis pixel and camera base ----------------
  logic [SIZE_W-1:0] w_c, h_c, col_c, row_c;
  logic [4:0]        cam_c;
  logic [ADDR_W-1:0] base_c;

  always_comb begin
    w_c   = clamp_size(in_item.image_width, W_LIM);
    h_c   = clamp_size(in_item.image_height, H_LIM);
    col_c = round_clamp(in_item.x_pos, w_c);
    row_c = round_clamp(in_item.y_pos, h_c);
    // camera wraps; at most three subtracts for a 2-bit camera field
    cam_c = 5'(in_item.camera);
    for (int i = 0; i < 3; i++) begin
      if (cam_c >= CAM_MOD) cam_c = cam_c - CAM_MOD;
    end
    base_c = ADDR_W'(cam_c) * ADDR_W'(CAM_SPAN);
  end

  logic              s2_valid_r;
  logic              s2_clear_r;
  logic [OWNER_W-1:0] s2_point_r;
  logic [SIZE_W-1:0] s2_w_r, s2_col_r, s2_row_r;
  logic [ADDR_W-1:0] s2_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_clear_r <= (in_item.cmd == CMD_CLEAR);
      s2_point_r <= in_item.point_index;
      s2_w_r     <= w_c;
      s2_col_r   <= col_c;
      s2_row_r   <= row_c;
      s2_base_r  <= base_c;
    end
  end

  // ---------------- stage 3: linear pixel and map address ----------------
  logic [PROD_W-1:0] pix_c;
  pccc_tag_t         s3_tag_nxt;
  pccc_tag_t         s3_tag_r;
  logic [ADDR_W-1:0] s3_addr_nxt;
  logic [ADDR_W-1:0] s3_addr_r;

  always_comb begin
    pix_c = ({{SIZE_W{1'b0}}, s2_row_r} * {{SIZE_W{1'b0}}, s2_w_r})
          + {{SIZE_W{1'b0}}, s2_col_r};
    s3_tag_nxt.valid       = s2_valid_r;
    s3_tag_nxt.clear       = s2_clear_r;
    s3_tag_nxt.point_index = s2_point_r;
    s3_tag_nxt.pix         = s2_clear_r ? '0 : pix_c[PIX_W-1:0];
    s3_addr_nxt            = s2_base_r + ADDR_W'(pix_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r <= '0;
    end else if (adv) begin
      s3_tag_r <= s3_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_addr_r <= s3_addr_nxt;
    end
  end

  assign out_tag  = s3_tag_r;
  assign out_addr = s3_addr_r;

endmodule

`default_nettype wire

>>> sv/pixel_claim_collision_checker.sv
// Top level of the pixel claim collision checker: stream ports, sequencer,
// map read-modify-write with forwarding. Depends on pccc_pkg, pccc_coord
// and pccc_owner_mem.
//
// Keeps a claimed bit and an owner for every pixel of every camera in one
// single-port-write, single-port-read memory of MAX_CAMERAS*MAX_WIDTH*
// MAX_HEIGHT entries. Point transactions (tuser 1) stream at one per cycle
// while out_tready does not stall the output register; each result passes
// the input register, the two address stages, the registered memory read
// and the output register. A same-pixel point right behind another is
// resolved by forwarding the in-flight owner. A clear transaction (tuser 0)
// drains the pipeline, then writes every map entry in turn, one per cycle
// (MAP_DEPTH entries, 65536 at the defaults), and returns one all-zero
// result once the output register is free; no input is taken meanwhile.
// A sweep over all entries also runs after reset, with in_tready low.
`default_nettype none

module pixel_claim_collision_checker #(
  parameter int MAX_CAMERAS = 4,
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // input stream
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [1:0] camera, [17:2] x_pos, [33:18] y_pos, [41:34] image_width,
  // [49:42] image_height, [65:50] point_index, [71:66] zero
  input  wire [pccc_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] cmd
  input  wire                             in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [13:0] pixel_index, [29:14] previous_owner, [31:30] zero
  output logic [pccc_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] collision
  output logic                            out_tuser
);
  import pccc_pkg::*;

  localparam int MAP_DEPTH = MAX_CAMERAS * MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

  // pipeline moves whenever the output register can take a result
  logic adv;
  logic in_fire;

  pccc_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_busy_r, clr_busy_nxt;
  logic              sweep_done;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = (state_r == ST_RUN) && !clr_busy_r && adv;
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- stage 1: accepted transaction ----------------
  pccc_item_t item_c;
  pccc_item_t s1_item_r;
  logic       s1_valid_r;

  always_comb begin
    item_c.cmd          = in_tuser;
    item_c.camera       = in_tdata[1:0];
    item_c.x_pos        = in_tdata[17:2];
    item_c.y_pos        = in_tdata[33:18];
    item_c.image_width  = in_tdata[41:34];
    item_c.image_height = in_tdata[49:42];
    item_c.point_index  = in_tdata[65:50];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= item_c;
    end
  end

  // ---------------- stages 2-3: address ----------------
  pccc_tag_t         s3_tag;
  logic [ADDR_W-1:0] s3_addr;

  pccc_coord #(
    .MAX_CAMERAS (MAX_CAMERAS),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .ADDR_W      (ADDR_W)
  ) u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (s1_valid_r),
    .in_item  (s1_item_r),
    .out_tag  (s3_tag),
    .out_addr (s3_addr)
  );

  // ---------------- stage 4: read data, forward, write back ----------------
  pccc_tag_t          s4_tag_r;
  logic [ADDR_W-1:0]  s4_addr_r;
  logic               fwd_r;
  logic [OWNER_W-1:0] fwd_owner_r;
  logic               s4_point;
  logic               s3_point;

  assign s4_point = s4_tag_r.valid && !s4_tag_r.clear;
  assign s3_point = s3_tag.valid && !s3_tag.clear;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r <= '0;
    end else if (adv) begin
      s4_tag_r <= s3_tag;
    end
  end

  // read issued with stage 3 sees stale data if stage 4 writes the same entry
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_addr_r   <= s3_addr;
      fwd_r       <= s4_point && (s4_addr_r == s3_addr);
      fwd_owner_r <= s4_tag_r.point_index;
    end
  end

  // memory port muxing: sweep owns the write port outside ST_RUN
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ENTRY_W-1:0] mem_rdata;

  always_comb begin
    if (state_r == ST_RUN) begin
      mem_we    = adv && s4_point;
      mem_waddr = s4_addr_r;
      mem_wdata = {1'b1, s4_tag_r.point_index};
    end else begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end
    mem_re = adv && s3_point;
  end

  pccc_owner_mem #(
    .DEPTH  (MAP_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (s3_addr),
    .rd_data (mem_rdata)
  );

  // previous claim as seen by this point
  logic               hit_c;
  logic [OWNER_W-1:0] prev_c;

  always_comb begin
    hit_c  = fwd_r || mem_rdata[ENTRY_W-1];
    prev_c = fwd_r ? fwd_owner_r
                   : (mem_rdata[ENTRY_W-1] ? mem_rdata[OWNER_W-1:0] : '0);
  end

  // ---------------- sequencer: reset sweep, clear sweep ----------------
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clr_busy_nxt = clr_busy_r;
    sweep_done   = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          state_nxt    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_fire && (in_tuser == CMD_CLEAR)) clr_busy_nxt = 1'b1;
        if (adv && s4_tag_r.valid && s4_tag_r.clear) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          // last entry: wait until the output register can take the answer
          clr_addr_nxt = clr_addr_r;
          if (adv) begin
            clr_addr_nxt = '0;
            clr_busy_nxt = 1'b0;
            sweep_done   = 1'b1;
            state_nxt    = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt    = ST_INIT;
        clr_addr_nxt = '0;
        clr_busy_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      clr_addr_r <= '0;
      clr_busy_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // ---------------- output register ----------------
  logic               out_valid_r, out_valid_nxt;
  logic               out_coll_r, out_coll_nxt;
  logic [PIX_W-1:0]   out_pix_r, out_pix_nxt;
  logic [OWNER_W-1:0] out_owner_r, out_owner_nxt;

  always_comb begin
    priority if (sweep_done) begin
      // clear answers once, all zero; register is free here
      out_valid_nxt = 1'b1;
      out_coll_nxt  = 1'b0;
      out_pix_nxt   = '0;
      out_owner_nxt = '0;
    end else if (adv) begin
      out_valid_nxt = s4_point;
      out_coll_nxt  = hit_c;
      out_pix_nxt   = s4_tag_r.pix;
      out_owner_nxt = prev_c;
    end else begin
      // receiver stalled: hold the pending result
      out_valid_nxt = out_valid_r;
      out_coll_nxt  = out_coll_r;
      out_pix_nxt   = out_pix_r;
      out_owner_nxt = out_owner_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_coll_r  <= out_coll_nxt;
    out_pix_r   <= out_pix_nxt;
    out_owner_r <= out_owner_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_coll_r;
  assign out_tdata  = {(OUT_DATA_W - OWNER_W - PIX_W)'(0), out_owner_r, out_pix_r};

endmodule

`default_nettype wire
